@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

@@ hw/rtl/asd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package asd_pkg;

  localparam int unsigned AxisW   = 16;
  localparam int unsigned SquareW = 31;
  localparam int unsigned SumW    = 32;
  localparam int unsigned RootW   = 16;
  localparam int unsigned DsumW   = 18;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned ThrW    = 18;
  localparam int unsigned LatchW  = 16;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CFG_SHAKE_THRESHOLD = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_LATCH_TIME_MS   = 1'b1;

  localparam logic [ThrW-1:0]   THRESHOLD_RST = 18'd4096;
  localparam logic [LatchW-1:0] LATCH_RST     = 16'd1000;

  typedef struct packed {
    logic signed [AxisW-1:0] accel_x;
    logic signed [AxisW-1:0] accel_y;
    logic signed [AxisW-1:0] accel_z;
    logic [TimeW-1:0]        now_ms;
  } asd_in_t;

  typedef struct packed {
    logic              shake_active;
    logic              state_changed;
    logic              detected;
    logic [RootW-1:0]  magnitude_delta;
    logic [DsumW-1:0]  axis_delta_sum;
  } asd_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LANE,
    ST_SUM,
    ST_START,
    ST_ROOT,
    ST_DONE
  } asd_state_e;

  typedef struct packed {
    logic in_ready;
    logic lane_en;
    logic sum_en;
    logic root_start;
    logic commit;
  } asd_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/asd_axis_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none

module asd_axis_lane import asd_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic signed [AxisW-1:0] cur_i,
  input  wire logic signed [AxisW-1:0] prev_i,
  output logic [SquareW-1:0]           sq_o,
  output logic [AxisW-1:0]             adiff_o
);

  logic signed [2*AxisW-1:0] prod;
  logic signed [AxisW:0]     diff;
  logic [AxisW:0]            diff_abs;
  logic [SquareW-1:0]        sq_q;
  logic [AxisW-1:0]          adiff_q;

  assign prod     = cur_i * cur_i;
  assign diff     = {cur_i[AxisW-1], cur_i} - {prev_i[AxisW-1], prev_i};
  assign diff_abs = diff[AxisW] ? (~diff + 1'b1) : diff;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q    <= prod[SquareW-1:0];
      adiff_q <= diff_abs[AxisW-1:0];
    end
  end

  assign sq_o    = sq_q;
  assign adiff_o = adiff_q;

endmodule

`default_nettype wire

@@ hw/rtl/asd_isqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module asd_isqrt import asd_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [SumW-1:0] n_i,
  output logic                 done_o,
  output logic [RootW-1:0]     root_o
);

  localparam int unsigned RemW = RootW + 2;
  localparam int unsigned CntW = $clog2(RootW);

  logic [SumW-1:0]  n_q, n_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [RemW+1:0]  rem_t;
  logic [RemW+1:0]  trial;

  assign rem_t = {rem_q, n_q[SumW-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};

  always_comb begin
    n_d    = n_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      n_d    = n_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      n_d   = {n_q[SumW-3:0], 2'b00};
      cnt_d = cnt_q + 1'b1;
      if (rem_t >= trial) begin
        rem_d  = RemW'(rem_t - trial);
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_t[RemW-1:0];
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      if (cnt_q == CntW'(RootW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

  `ASSERT_NEVER(a_start_busy, start_i && busy_q, "isqrt started while busy")
  `ASSERT_CLK(a_done_after_busy, done_q |-> $past(busy_q), "isqrt done without work")
  `ASSERT_CLK(a_idle_cnt, !busy_q |-> cnt_q == '0, "isqrt step count not cleared")

endmodule

`default_nettype wire

@@ hw/rtl/accel_shake_detector.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Shake detector for one three-axis accelerometer sample per request.
// The input channel carries the raw x, y and z counts and the millisecond
// time of the sample. The output channel carries one result per request:
// the shake flag, whether it changed, whether this sample triggered, and
// the magnitude and per-axis deltas against the previous sample.
// Configuration is a write port: index 0 sets the threshold in counts,
// index 1 the latch time in milliseconds.
// A request passes from acceptance to a valid result through the axis
// lanes, the merge, the square root unit, which resolves one root bit per
// cycle, and the commit.
// A new request is accepted only in the cycle after the previous one has
// committed, so no new request is taken while one is in flight.
// Reset clears the previous sample, the shake flag and its time stamp, and
// loads the default threshold and latch time. When the receiver stalls,
// the result stays in the output register; the next request is still
// taken and held at its commit until the output register frees up.

`include "assert_macros.svh"

module accel_shake_detector import asd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire asd_in_t             in_req_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output asd_out_t                 out_req_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [ThrW-1:0]     cfg_wdata_i
);

  asd_state_e state_q, state_d;
  asd_ctrl_t  ctrl;

  asd_in_t           sample_q;
  logic [ThrW-1:0]   thr_q;
  logic [LatchW-1:0] latch_q;

  logic signed [AxisW-1:0] prev_x_q, prev_y_q, prev_z_q;
  logic [RootW-1:0]        prev_mag_q;
  logic                    have_prev_q;
  logic                    flag_q, flag_d;
  logic [TimeW-1:0]        last_time_q, last_time_d;

  logic [SquareW-1:0] sq_x, sq_y, sq_z;
  logic [AxisW-1:0]   ad_x, ad_y, ad_z;
  logic [SumW-1:0]    sq_sum_q;
  logic [DsumW-1:0]   dsum_q;

  logic             root_done;
  logic [RootW-1:0] mag;

  logic             out_valid_q;
  asd_out_t         out_q, out_d;

  logic [RootW-1:0] dmag;
  logic [DsumW-1:0] dsum;
  logic             trig;
  logic             flag_mid;
  logic [TimeW-1:0] elapsed;

  asd_axis_lane u_lane_x (
    .clk_i   (clk_i),
    .en_i    (ctrl.lane_en),
    .cur_i   (sample_q.accel_x),
    .prev_i  (prev_x_q),
    .sq_o    (sq_x),
    .adiff_o (ad_x)
  );

  asd_axis_lane u_lane_y (
    .clk_i   (clk_i),
    .en_i    (ctrl.lane_en),
    .cur_i   (sample_q.accel_y),
    .prev_i  (prev_y_q),
    .sq_o    (sq_y),
    .adiff_o (ad_y)
  );

  asd_axis_lane u_lane_z (
    .clk_i   (clk_i),
    .en_i    (ctrl.lane_en),
    .cur_i   (sample_q.accel_z),
    .prev_i  (prev_z_q),
    .sq_o    (sq_z),
    .adiff_o (ad_z)
  );

  asd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl.root_start),
    .n_i     (sq_sum_q),
    .done_o  (root_done),
    .root_o  (mag)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_LANE;
      ST_LANE:  state_d = ST_SUM;
      ST_SUM:   state_d = ST_START;
      ST_START: state_d = ST_ROOT;
      ST_ROOT:  if (root_done) state_d = ST_DONE;
      ST_DONE:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state_q)
      ST_IDLE:  ctrl.in_ready   = 1'b1;
      ST_LANE:  ctrl.lane_en    = 1'b1;
      ST_SUM:   ctrl.sum_en     = 1'b1;
      ST_START: ctrl.root_start = 1'b1;
      ST_ROOT:  ctrl = '0;
      ST_DONE:  ctrl.commit     = !out_valid_q || out_ready_i;
      default:  ctrl = '0;
    endcase
  end

  always_comb begin
    dmag = '0;
    dsum = '0;
    if (have_prev_q) begin
      dmag = (mag >= prev_mag_q) ? (mag - prev_mag_q) : (prev_mag_q - mag);
      dsum = dsum_q;
    end
    trig        = have_prev_q && (({2'b00, dmag} > thr_q) || (dsum > thr_q));
    last_time_d = trig ? sample_q.now_ms : last_time_q;
    flag_mid    = flag_q || trig;
    elapsed     = sample_q.now_ms - last_time_d;
    flag_d      = flag_mid && !(elapsed >= {{(TimeW-LatchW){1'b0}}, latch_q});

    out_d.shake_active    = flag_d;
    out_d.state_changed   = flag_d != flag_q;
    out_d.detected        = trig;
    out_d.magnitude_delta = dmag;
    out_d.axis_delta_sum  = dsum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= THRESHOLD_RST;
      latch_q     <= LATCH_RST;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_z_q    <= '0;
      prev_mag_q  <= '0;
      have_prev_q <= 1'b0;
      flag_q      <= 1'b0;
      last_time_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SHAKE_THRESHOLD: thr_q   <= cfg_wdata_i;
          CFG_LATCH_TIME_MS:   latch_q <= cfg_wdata_i[LatchW-1:0];
          default:             thr_q   <= thr_q;
        endcase
      end
      if (ctrl.commit) begin
        prev_x_q    <= sample_q.accel_x;
        prev_y_q    <= sample_q.accel_y;
        prev_z_q    <= sample_q.accel_z;
        prev_mag_q  <= mag;
        have_prev_q <= 1'b1;
        flag_q      <= flag_d;
        last_time_q <= last_time_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.in_ready && in_valid_i) begin
      sample_q <= in_req_i;
    end
    if (ctrl.sum_en) begin
      sq_sum_q <= {1'b0, sq_x} + {1'b0, sq_y} + {1'b0, sq_z};
      dsum_q   <= {2'b00, ad_x} + {2'b00, ad_y} + {2'b00, ad_z};
    end
    if (ctrl.commit) begin
      out_q <= out_d;
    end
  end

  assign in_ready_o  = ctrl.in_ready;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  `ASSERT_CLK(a_out_hold, $fell(out_valid_q) |-> $past(out_ready_i),
              "result dropped before it was taken")
  `ASSERT_CLK(a_root_in_wait, root_done |-> state_q == ST_ROOT,
              "square root finished outside its wait state")
  `ASSERT_CLK(a_commit_done, ctrl.commit |=> out_valid_q && state_q == ST_IDLE,
              "commit did not present a result")

endmodule

`default_nettype wire
